// File: hdl/msc_pkg.sv
// ----------------------------------------------------------------------------
// Minimum square count package
// Widths, constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int TARGET_W           = 12;
    localparam int COUNT_W            = 3;
    localparam int MAX_TARGET_DEFAULT = 4095;

    localparam logic [COUNT_W-1:0] NO_COUNT  = 3'd7;
    localparam logic [COUNT_W-1:0] MAX_COUNT = 3'd4;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic target_zero;
        logic sq_le_v;
        logic v_last;
    } t_status;

endpackage

// File: hdl/msc_ifs.sv
// ----------------------------------------------------------------------------
// Minimum square count channels
// Valid/ready channels for the target word and the square count word.
// ----------------------------------------------------------------------------
interface msc_target_if;
    import msc_pkg::*;

    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target;

    modport source (output valid, output target, input ready);
    modport sink (input valid, input target, output ready);
endinterface

interface msc_count_if;
    import msc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] square_count;

    modport source (output valid, output square_count, input ready);
    modport sink (input valid, input square_count, output ready);
endinterface

// File: hdl/msc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/msc_ctrl.sv
// ----------------------------------------------------------------------------
// Minimum square count controller
// Sequences table building per target and hands the result to the output.
// ----------------------------------------------------------------------------
module msc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  msc_pkg::t_status i_status,
    output msc_pkg::t_cmd   o_cmd
);
    import msc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.load = i_in_valid;
            end
            S_RUN: begin
                cmd.step   = i_status.sq_le_v;
                cmd.finish = !i_status.sq_le_v;
            end
            S_DONE: begin
                cmd.push = !r_out_valid || i_out_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd.load) begin
                        r_state <= i_status.target_zero ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (cmd.finish && i_status.v_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (cmd.push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: hdl/msc_dp.sv
// ----------------------------------------------------------------------------
// Minimum square count datapath
// Square stepping, table addressing and running minimum over table reads.
// ----------------------------------------------------------------------------
module msc_dp #(
    parameter int MAX_TARGET = msc_pkg::MAX_TARGET_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [msc_pkg::TARGET_W-1:0] i_target,
    input  msc_pkg::t_cmd            i_cmd,
    output msc_pkg::t_status         o_status,
    output logic [msc_pkg::COUNT_W-1:0] o_square_count
);
    import msc_pkg::*;

    localparam int VAL_W = $clog2(MAX_TARGET + 1);
    localparam int SQ_W  = VAL_W + 2;
    localparam int CMP_W = (VAL_W > TARGET_W) ? VAL_W : TARGET_W;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_TARGET);

    logic [VAL_W-1:0]   r_n;
    logic [VAL_W-1:0]   r_v;
    logic [SQ_W-1:0]    r_sq;
    logic [SQ_W-1:0]    r_j;
    logic [COUNT_W-1:0] r_best;
    logic               r_pend;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_out_count;

    logic [CMP_W-1:0]   target_ext;
    logic [VAL_W-1:0]   target_sat;
    logic [COUNT_W-1:0] rd_data;
    logic [COUNT_W-1:0] cand;
    logic [COUNT_W-1:0] fin_best;
    logic [VAL_W-1:0]   rd_addr;
    logic [VAL_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               wr_en;

    assign target_ext = CMP_W'(i_target);
    assign target_sat = (target_ext > MAX_EXT) ? VAL_W'(MAX_EXT) : VAL_W'(target_ext);

    assign cand     = rd_data + COUNT_W'(1);
    assign fin_best = (r_pend && (cand < r_best)) ? cand : r_best;
    assign rd_addr  = VAL_W'(SQ_W'(r_v) - r_sq);

    assign wr_en   = i_cmd.load || i_cmd.finish;
    assign wr_addr = i_cmd.load ? '0 : r_v;
    assign wr_data = i_cmd.load ? '0 : fin_best;

    msc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_TARGET + 1)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.step),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.finish) begin
            r_sq   <= SQ_W'(1);
            r_j    <= SQ_W'(1);
            r_best <= NO_COUNT;
            r_pend <= 1'b0;
        end else if (i_cmd.step) begin
            r_sq   <= r_sq + {r_j[SQ_W-2:0], 1'b1};
            r_j    <= r_j + SQ_W'(1);
            r_best <= fin_best;
            r_pend <= 1'b1;
        end
        if (i_cmd.load) begin
            r_n     <= target_sat;
            r_v     <= VAL_W'(1);
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_v     <= r_v + VAL_W'(1);
            r_count <= fin_best;
        end
        if (i_cmd.push) begin
            r_out_count <= r_count;
        end
    end

    assign o_status.target_zero = (i_target == '0);
    assign o_status.sq_le_v     = (SQ_W'(r_v) >= r_sq);
    assign o_status.v_last      = (r_v == r_n);
    assign o_square_count       = r_out_count;

`ifndef ASSERT_OFF
    a_finish_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_pend)
        else $error("Table entry finished without any square tried.");

    a_read_below_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (rd_addr < r_v))
        else $error("Table read at or above the entry being built.");

    a_entry_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (fin_best <= MAX_COUNT))
        else $error("Square count above four written to the table.");

    a_count_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_out_count <= MAX_COUNT))
        else $error("Square count out of range presented.");
`endif

endmodule

// File: hdl/min_square_count_dp_unit.sv
// ----------------------------------------------------------------------------
// Minimum square count unit
// Least number of perfect squares summing to a target, by table building.
// ----------------------------------------------------------------------------
// A target word enters on i_target; one square count word leaves on o_count
// for each target. Both channels use valid/ready, a word moving when both
// are high. Targets above MAX_TARGET are treated as MAX_TARGET.
// For a target n the table is rebuilt from entry 1 to n. Entry v takes one
// table read for each square not above v, then one write of the entry. The
// count word is presented after the last entry is written, and only then can
// the next target be taken; the single read port of the table RAM sets the
// pace. A target of zero skips the table work and goes straight to the
// output register.
// The result sits in an output register, so the next target is taken as
// soon as the table work is done, even while the receiver stalls; the
// following result then waits until the held word has been taken.
// Synchronous reset returns the controller to idle and drops the output
// valid; the table contents need no clearing, as every entry is written
// before it is read.
// ----------------------------------------------------------------------------
module min_square_count_dp_unit #(
    parameter int MAX_TARGET = msc_pkg::MAX_TARGET_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msc_target_if.sink   i_target,
    msc_count_if.source  o_count
);
    import msc_pkg::*;

    t_cmd    cmd;
    t_status status;

    msc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_target.valid),
        .o_in_ready  (i_target.ready),
        .o_out_valid (o_count.valid),
        .i_out_ready (o_count.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    msc_dp #(
        .MAX_TARGET (MAX_TARGET)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_target       (i_target.target),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_square_count (o_count.square_count)
    );

endmodule

// File: tb/sv/tb_min_square_count_dp_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minimum square count unit testbench
// Sends target words and checks every square count word against a typed
// count or a local table-building predictor. A short directed table comes first,
// then random targets, mostly small, in phases with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_min_square_count_dp_unit;
    import msc_pkg::*;

    localparam int LIMIT_TARGET = MAX_TARGET_DEFAULT;
    localparam int N_DIRECTED   = 24;
    localparam int N_PER_PHASE  = 25;
    localparam int N_PHASES     = 4;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                typed;
        logic [COUNT_W-1:0]  count;
    } t_target_vec;

    localparam t_target_vec DIRECTED_VECS [0:N_DIRECTED-1] = '{
        '{12'd0,    1'b1, 3'd0},
        '{12'd1,    1'b1, 3'd1},
        '{12'd2,    1'b0, 3'd0},
        '{12'd3,    1'b0, 3'd0},
        '{12'd4,    1'b1, 3'd1},
        '{12'd5,    1'b0, 3'd0},
        '{12'd6,    1'b0, 3'd0},
        '{12'd7,    1'b1, 3'd4},
        '{12'd8,    1'b0, 3'd0},
        '{12'd9,    1'b1, 3'd1},
        '{12'd12,   1'b0, 3'd0},
        '{12'd15,   1'b1, 3'd4},
        '{12'd16,   1'b1, 3'd1},
        '{12'd25,   1'b1, 3'd1},
        '{12'd28,   1'b0, 3'd0},
        '{12'd100,  1'b1, 3'd1},
        '{12'd127,  1'b0, 3'd0},
        '{12'd128,  1'b0, 3'd0},
        '{12'd255,  1'b0, 3'd0},
        '{12'd256,  1'b1, 3'd1},
        '{12'd1024, 1'b1, 3'd1},
        '{12'd2048, 1'b0, 3'd0},
        '{12'd4095, 1'b1, 3'd4},
        '{12'd0,    1'b1, 3'd0}
    };

    logic i_clk;
    logic i_rst_n;

    msc_target_if target_ch ();
    msc_count_if  count_ch ();

    min_square_count_dp_unit #(
        .MAX_TARGET(LIMIT_TARGET)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_target(target_ch),
        .o_count (count_ch)
    );

    logic [COUNT_W-1:0] count_table [0:LIMIT_TARGET];
    logic [COUNT_W-1:0] count_expect_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int targets_sent   = 0;
    int counts_checked = 0;
    int mismatches     = 0;
    int largest_target = 0;

    function automatic logic [COUNT_W-1:0] least_squares(input logic [TARGET_W-1:0] tgt);
        int unsigned n;
        int unsigned v;
        int unsigned j;
        int unsigned sq;
        int unsigned best;
        int unsigned cand;
        n = 32'(tgt);
        if (n > LIMIT_TARGET) begin
            n = LIMIT_TARGET;
        end
        count_table[0] = '0;
        for (v = 1; v <= n; v++) begin
            best = 32'(NO_COUNT);
            j    = 1;
            sq   = 1;
            while (sq <= v) begin
                cand = 1 + 32'(count_table[v - sq]);
                if (cand < best) begin
                    best = cand;
                end
                sq = sq + 2 * j + 1;
                j++;
            end
            count_table[v] = best[COUNT_W-1:0];
        end
        return count_table[n];
    endfunction

    task automatic send_target(input logic [TARGET_W-1:0] tgt, input logic typed,
                               input logic [COUNT_W-1:0] typed_count);
        while ($urandom_range(99) < send_idle_pct) begin
            target_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        target_ch.valid  <= 1'b1;
        target_ch.target <= tgt;
        @(posedge i_clk);
        while (!target_ch.ready) begin
            @(posedge i_clk);
        end
        count_expect_q.push_back(typed ? typed_count : least_squares(tgt));
        targets_sent++;
        if (int'(tgt) > largest_target) begin
            largest_target = int'(tgt);
        end
    endtask

    task automatic drain_counts();
        target_ch.valid <= 1'b0;
        while (count_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [TARGET_W-1:0] random_target();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return TARGET_W'($urandom_range(127));
        end else if (pick < 95) begin
            return TARGET_W'($urandom_range(1023));
        end
        return TARGET_W'($urandom_range(4095));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        count_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            count_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && count_ch.valid && count_ch.ready) begin
            if (count_expect_q.size() == 0) begin
                $display("%0t: unexpected count word, expected none, actual %0d",
                         $time, count_ch.square_count);
                mismatches++;
            end else begin
                if (count_ch.square_count !== count_expect_q[0]) begin
                    $display("%0t: square_count mismatch, expected %0d, actual %0d",
                             $time, count_expect_q[0], count_ch.square_count);
                    mismatches++;
                end
                void'(count_expect_q.pop_front());
                counts_checked++;
            end
        end
    end

    initial begin
        int idle_by_phase  [0:N_PHASES-1];
        int stall_by_phase [0:N_PHASES-1];
        idle_by_phase  = '{0, 72, 0, 38};
        stall_by_phase = '{0, 0, 72, 38};
        i_rst_n          <= 1'b0;
        target_ch.valid  <= 1'b0;
        target_ch.target <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_target(DIRECTED_VECS[i].target, DIRECTED_VECS[i].typed,
                        DIRECTED_VECS[i].count);
        end
        drain_counts();

        for (int p = 0; p < N_PHASES; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            for (int i = 0; i < N_PER_PHASE; i++) begin
                send_target(random_target(), 1'b0, '0);
            end
            drain_counts();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d target words and checked %0d count words, targets up to %0d.",
                 targets_sent, counts_checked, largest_target);
        $display("Phases: no idling, sender gaps, receiver stalls, both; drained between.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timeout with %0d count words outstanding.", count_expect_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
